[rtl/ilg_pkg.sv]
// Shared types, constants and constant functions of the input levels and gamma block.
`default_nettype none

package ilg_pkg;

  // Pixel width and full-scale value.
  localparam int unsigned PIXEL_BITS = 8;
  localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

  // Register widths and the APB address width.
  localparam int unsigned LVL_W   = 11;
  localparam int unsigned GAM_W   = 12;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Effective register limits and reset values.
  localparam logic [LVL_W-1:0] BLACK_MAX   = 11'd1014;
  localparam logic [LVL_W-1:0] WHITE_MAX   = 11'd1024;
  localparam logic [LVL_W-1:0] LEVEL_GAP   = 11'd10;
  localparam logic [GAM_W-1:0] GAMMA_MIN   = 12'd26;
  localparam logic [GAM_W-1:0] GAMMA_MAX   = 12'd2560;
  localparam logic [LVL_W-1:0] BLACK_RESET = 11'd0;
  localparam logic [LVL_W-1:0] WHITE_RESET = 11'd1024;
  localparam logic [GAM_W-1:0] GAMMA_RESET = 12'd256;

  // Datapath widths.
  localparam int unsigned DEN_W     = PIXEL_BITS + 10;
  localparam int unsigned NUM_W     = PIXEL_BITS + 11;
  localparam int unsigned VQ_W      = 32;
  localparam int unsigned K_W       = 5;
  localparam int unsigned FRAC_BITS = 20;
  localparam int unsigned L_W       = FRAC_BITS + 6;
  localparam int unsigned E_W       = L_W + 8;
  localparam int unsigned EI_W      = E_W - FRAC_BITS;
  localparam int unsigned R_W       = VQ_W + 1;
  localparam int unsigned SH_W      = $clog2(R_W);

  // Register indexes on the APB port.
  typedef enum logic [1:0] {
    REG_BLACK = 2'd0,
    REG_WHITE = 2'd1,
    REG_GAMMA = 2'd2
  } reg_idx_e;

  // Effective configuration handed to the datapath.
  typedef struct packed {
    logic [DEN_W-1:0] black_scaled;
    logic [DEN_W-1:0] range;
    logic [GAM_W-1:0] gamma;
  } cfg_t;

  // Early decisions that bypass the power computation.
  typedef struct packed {
    logic zero;
    logic sat;
  } flags_t;

  // Floor square root of a 64-bit value.
  function automatic logic [63:0] isqrt64(input logic [63:0] a);
    logic [63:0] a_v;
    logic [63:0] res;
    logic [63:0] bt;
    a_v = a;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (a_v >= res + bt) begin
        a_v = a_v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Q0.32 factor 2^(-2^-j), built by repeated square roots.
  function automatic logic [63:0] exp_coef(input int j);
    logic [63:0] c;
    c = isqrt64(64'd1 << 63);
    for (int i = 1; i < FRAC_BITS; i++) begin
      if (i < j) begin
        c = isqrt64(c << 32);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/ilg_if.sv]
// Stream interfaces for the input and result pixels.
`default_nettype none

interface ilg_in_if;
  logic                            valid;
  logic                            ready;
  logic [ilg_pkg::PIXEL_BITS-1:0]  pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface ilg_out_if;
  logic                            valid;
  logic                            ready;
  logic [ilg_pkg::PIXEL_BITS-1:0]  pixel_out;
  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

[rtl/ilg_cfg.sv]
// APB register file and derivation of the effective black, white and gamma values.
`default_nettype none

module ilg_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [ilg_pkg::PADDR_W-1:0]   paddr_i,
  input  wire logic [ilg_pkg::PDATA_W-1:0]   pwdata_i,
  output logic      [ilg_pkg::PDATA_W-1:0]   prdata_o,
  output ilg_pkg::cfg_t                      cfg_o
);
  import ilg_pkg::*;

  logic [LVL_W-1:0] black_q;
  logic [LVL_W-1:0] white_q;
  logic [GAM_W-1:0] gamma_q;
  logic             wr_en;
  reg_idx_e         idx;
  logic [LVL_W-1:0] b0, w0, b1, w1;
  logic [GAM_W-1:0] g_eff;
  cfg_t             cfg_d, cfg_q;

  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = reg_idx_e'(paddr_i[3:2]);

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q <= BLACK_RESET;
      white_q <= WHITE_RESET;
      gamma_q <= GAMMA_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_BLACK: black_q <= pwdata_i[LVL_W-1:0];
        REG_WHITE: white_q <= pwdata_i[LVL_W-1:0];
        REG_GAMMA: gamma_q <= pwdata_i[GAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (idx)
      REG_BLACK: prdata_o = PDATA_W'(black_q);
      REG_WHITE: prdata_o = PDATA_W'(white_q);
      REG_GAMMA: prdata_o = PDATA_W'(gamma_q);
      default:   prdata_o = '0;
    endcase
  end

  // Clamp the levels and gamma, keep the minimum gap and scale by the pixel full scale.
  always_comb begin
    b0 = (black_q > BLACK_MAX) ? BLACK_MAX : black_q;
    w0 = (white_q > WHITE_MAX) ? WHITE_MAX : white_q;
    if (b0 + LEVEL_GAP > w0) begin
      b1 = (w0 >= LEVEL_GAP) ? w0 - LEVEL_GAP : '0;
    end else begin
      b1 = b0;
    end
    w1 = (w0 < b1 + LEVEL_GAP) ? b1 + LEVEL_GAP : w0;
    if (gamma_q < GAMMA_MIN) begin
      g_eff = GAMMA_MIN;
    end else if (gamma_q > GAMMA_MAX) begin
      g_eff = GAMMA_MAX;
    end else begin
      g_eff = gamma_q;
    end
    cfg_d.black_scaled = DEN_W'(PIX_MAX) * DEN_W'(b1);
    cfg_d.range        = DEN_W'(PIX_MAX) * DEN_W'(w1 - b1);
    cfg_d.gamma        = g_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.black_scaled <= '0;
      cfg_q.range        <= DEN_W'(PIX_MAX) * DEN_W'(WHITE_RESET);
      cfg_q.gamma        <= GAMMA_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/ilg_front.sv]
// Levels stage: offset, range compare, bit-per-stage divider and normalization.
`default_nettype none

module ilg_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             valid_i,
  input  wire logic [ilg_pkg::PIXEL_BITS-1:0]   pixel_i,
  input  ilg_pkg::cfg_t                         cfg_i,
  output logic                                  valid_o,
  output ilg_pkg::flags_t                       flags_o,
  output logic      [ilg_pkg::VQ_W-1:0]         mant_o,
  output logic      [ilg_pkg::K_W-1:0]          shift_o
);
  import ilg_pkg::*;

  // Leading zero count of a nonzero word.
  function automatic logic [K_W-1:0] lzc(input logic [VQ_W-1:0] v);
    logic [K_W-1:0] n;
    n = '0;
    for (int i = 0; i < VQ_W; i++) begin
      if (v[i]) begin
        n = K_W'(VQ_W - 1 - i);
      end
    end
    return n;
  endfunction

  logic                    x_v_q;
  logic [PIXEL_BITS-1:0]   x_q;
  logic signed [NUM_W-1:0] num;
  logic                    num_zero, num_sat;

  logic                    dv_q  [0:VQ_W];
  flags_t                  dfl_q [0:VQ_W];
  logic [DEN_W-1:0]        rem_q [0:VQ_W];
  logic [VQ_W-1:0]         quo_q [0:VQ_W];

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_v_q <= 1'b0;
    end else if (en_i) begin
      x_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= pixel_i;
    end
  end

  // Offset by the black point and compare against the range.
  assign num = signed'({1'b0, x_q, 10'b0}) - signed'({1'b0, cfg_i.black_scaled});
  assign num_zero = num[NUM_W-1] | (num == '0);
  assign num_sat  = !num_zero && (num[NUM_W-2:0] >= cfg_i.range);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= x_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dfl_q[0].zero <= num_zero;
      dfl_q[0].sat  <= num_sat;
      rem_q[0]      <= (num_zero | num_sat) ? '0 : num[DEN_W-1:0];
      quo_q[0]      <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar s = 0; s < VQ_W; s++) begin : g_div
    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {rem_q[s], 1'b0};
    assign ge    = trial >= {1'b0, cfg_i.range};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[s+1] <= dv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dfl_q[s+1] <= dfl_q[s];
        rem_q[s+1] <= ge ? DEN_W'(trial - {1'b0, cfg_i.range}) : trial[DEN_W-1:0];
        quo_q[s+1] <= {quo_q[s][VQ_W-2:0], ge};
      end
    end
  end

  // Normalize the quotient so its top bit is set.
  logic [K_W-1:0] lz;
  assign lz = lzc(quo_q[VQ_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= dv_q[VQ_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_o <= dfl_q[VQ_W];
      mant_o  <= quo_q[VQ_W] << lz;
      shift_o <= lz;
    end
  end

endmodule

`default_nettype wire

[rtl/ilg_log.sv]
// Log2 by repeated squaring, one bit per stage, then division of the exponent by gamma.
`default_nettype none

module ilg_log (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  ilg_pkg::flags_t                   flags_i,
  input  wire logic [ilg_pkg::VQ_W-1:0]     mant_i,
  input  wire logic [ilg_pkg::K_W-1:0]      shift_i,
  input  wire logic [ilg_pkg::GAM_W-1:0]    gamma_i,
  output logic                              valid_o,
  output ilg_pkg::flags_t                   flags_o,
  output logic      [ilg_pkg::E_W-1:0]      expo_o
);
  import ilg_pkg::*;

  logic                 lv  [0:FRAC_BITS];
  flags_t               lfl [0:FRAC_BITS];
  logic [VQ_W-1:0]      lm  [0:FRAC_BITS];
  logic [K_W-1:0]       lk  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] lf  [0:FRAC_BITS];

  assign lv[0]  = valid_i;
  assign lfl[0] = flags_i;
  assign lm[0]  = mant_i;
  assign lk[0]  = shift_i;
  assign lf[0]  = '0;

  // Square the mantissa; an overflow past 2.0 yields the next fraction bit.
  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_sq
    logic [2*VQ_W-1:0] sq;

    assign sq = (2*VQ_W)'(lm[s]) * (2*VQ_W)'(lm[s]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lv[s+1] <= 1'b0;
      end else if (en_i) begin
        lv[s+1] <= lv[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lfl[s+1] <= lfl[s];
        lk[s+1]  <= lk[s];
        lm[s+1]  <= sq[2*VQ_W-1] ? sq[2*VQ_W-1:VQ_W] : sq[2*VQ_W-2:VQ_W-1];
        lf[s+1]  <= {lf[s][FRAC_BITS-2:0], sq[2*VQ_W-1]};
      end
    end
  end

  // Minus log2 of the value in Q6.20, scaled by 256 as the dividend.
  logic [L_W-1:0] neg_log;
  assign neg_log = {(L_W-FRAC_BITS)'(lk[FRAC_BITS]) + 1'b1, {FRAC_BITS{1'b0}}}
                   - L_W'(lf[FRAC_BITS]);

  logic             dv  [0:E_W];
  flags_t           dfl [0:E_W];
  logic [E_W-1:0]   nq  [0:E_W];
  logic [GAM_W-1:0] rem [0:E_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv[0] <= 1'b0;
    end else if (en_i) begin
      dv[0] <= lv[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dfl[0] <= lfl[FRAC_BITS];
      nq[0]  <= {neg_log, 8'b0};
      rem[0] <= '0;
    end
  end

  // Restoring divider by gamma; dividend bits leave at the top, quotient enters below.
  for (genvar s = 0; s < E_W; s++) begin : g_div
    logic [GAM_W:0] trial;
    logic           ge;

    assign trial = {rem[s], nq[s][E_W-1]};
    assign ge    = trial >= {1'b0, gamma_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv[s+1] <= 1'b0;
      end else if (en_i) begin
        dv[s+1] <= dv[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dfl[s+1] <= dfl[s];
        rem[s+1] <= ge ? GAM_W'(trial - {1'b0, gamma_i}) : trial[GAM_W-1:0];
        nq[s+1]  <= {nq[s][E_W-2:0], ge};
      end
    end
  end

  assign valid_o = dv[E_W];
  assign flags_o = dfl[E_W];
  assign expo_o  = nq[E_W];

endmodule

`default_nettype wire

[rtl/ilg_exp.sv]
// Power of two from the exponent, one fraction bit per stage, then rescale to pixel range.
`default_nettype none

module ilg_exp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             valid_i,
  input  ilg_pkg::flags_t                       flags_i,
  input  wire logic [ilg_pkg::E_W-1:0]          expo_i,
  output logic                                  valid_o,
  output logic      [ilg_pkg::PIXEL_BITS-1:0]   pixel_o
);
  import ilg_pkg::*;

  localparam int unsigned SC_W = R_W + PIXEL_BITS + 1;

  logic           ev  [0:FRAC_BITS];
  flags_t         efl [0:FRAC_BITS];
  logic [E_W-1:0] ee  [0:FRAC_BITS];
  logic [R_W-1:0] er  [0:FRAC_BITS];

  assign ev[0]  = valid_i;
  assign efl[0] = flags_i;
  assign ee[0]  = expo_i;
  assign er[0]  = R_W'(1) << VQ_W;

  // Multiply by 2^(-2^-j) for each set fraction bit j.
  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_pow
    localparam logic [VQ_W-1:0] COEF = VQ_W'(exp_coef(s + 1));
    logic [R_W+VQ_W-1:0] prod;

    assign prod = (R_W+VQ_W)'(er[s]) * (R_W+VQ_W)'(COEF);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ev[s+1] <= 1'b0;
      end else if (en_i) begin
        ev[s+1] <= ev[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        efl[s+1] <= efl[s];
        ee[s+1]  <= ee[s];
        er[s+1]  <= ee[s][FRAC_BITS-1-s] ? prod[R_W+VQ_W-1:VQ_W] : er[s];
      end
    end
  end

  // Integer part of the exponent is a right shift.
  logic [EI_W-1:0] int_part;
  logic            sh_v_q;
  flags_t          sh_fl_q;
  logic [R_W-1:0]  sh_r_q;

  assign int_part = ee[FRAC_BITS][E_W-1:FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_v_q <= 1'b0;
    end else if (en_i) begin
      sh_v_q <= ev[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sh_fl_q <= efl[FRAC_BITS];
      sh_r_q  <= (int_part >= EI_W'(R_W)) ? '0 : er[FRAC_BITS] >> int_part[SH_W-1:0];
    end
  end

  // Scale to the pixel range with round half up, and apply the bypass cases.
  logic [SC_W-1:0]         scaled;
  logic [SC_W-VQ_W-1:0]    rounded;
  logic [PIXEL_BITS-1:0]   pix_d;

  assign scaled  = SC_W'(sh_r_q) * SC_W'(PIX_MAX) + (SC_W'(1) << (VQ_W - 1));
  assign rounded = scaled[SC_W-1:VQ_W];

  always_comb begin
    if (sh_fl_q.zero) begin
      pix_d = '0;
    end else if (sh_fl_q.sat) begin
      pix_d = PIX_MAX;
    end else if (rounded > (SC_W-VQ_W)'(PIX_MAX)) begin
      pix_d = PIX_MAX;
    end else begin
      pix_d = rounded[PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= sh_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixel_o <= pix_d;
    end
  end

endmodule

`default_nettype wire

[rtl/input_levels_gamma_map.sv]
// Top level of the input levels and gamma pixel remapper.
// Remaps one grey pixel per clock while the skid register is free: the pixel is offset by
// the black point, divided by the white-black range, clamped to 0..1, raised to 1/gamma and
// rounded back to full scale. The datapath is a 112-stage pipeline (an input register, a
// 32-stage bit-per-stage divider, a 20-stage squaring log2, a 34-stage division by gamma
// and a 20-stage power-of-two product, plus a few glue stages), and a new pixel is accepted
// every cycle while the skid register is free. A skid register at the output lets one more
// pixel in while a result waits; after that the whole pipeline holds until the result is
// taken. Registers sit on an APB port at byte addresses 0 (black), 4 (white) and 8 (gamma)
// and take effect via the register file, then the registered effective configuration.
`default_nettype none

module input_levels_gamma_map (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ilg_in_if.sink                             in_i,
  ilg_out_if.source                          out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ilg_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ilg_pkg::PDATA_W-1:0]   pwdata,
  output logic      [ilg_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import ilg_pkg::*;

  cfg_t                  cfg;
  logic                  en;
  logic                  fr_v, lg_v, ex_v;
  flags_t                fr_fl, lg_fl;
  logic [VQ_W-1:0]       fr_m;
  logic [K_W-1:0]        fr_k;
  logic [E_W-1:0]        lg_e;
  logic [PIXEL_BITS-1:0] ex_pix;
  logic                  skid_v_q;
  logic [PIXEL_BITS-1:0] skid_q;

  assign pready = 1'b1;

  ilg_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // The pipeline moves whenever the skid register is free.
  assign en       = !skid_v_q;
  assign in_i.ready = en;

  ilg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .pixel_i (in_i.pixel_in),
    .cfg_i   (cfg),
    .valid_o (fr_v),
    .flags_o (fr_fl),
    .mant_o  (fr_m),
    .shift_o (fr_k)
  );

  ilg_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .flags_i (fr_fl),
    .mant_i  (fr_m),
    .shift_i (fr_k),
    .gamma_i (cfg.gamma),
    .valid_o (lg_v),
    .flags_o (lg_fl),
    .expo_o  (lg_e)
  );

  ilg_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lg_v),
    .flags_i (lg_fl),
    .expo_i  (lg_e),
    .valid_o (ex_v),
    .pixel_o (ex_pix)
  );

  // Skid register catches the last stage when the sink stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_o.ready) begin
        skid_v_q <= 1'b0;
      end
    end else if (ex_v && !out_o.ready) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && ex_v && !out_o.ready) begin
      skid_q <= ex_pix;
    end
  end

  assign out_o.valid     = skid_v_q | ex_v;
  assign out_o.pixel_out = skid_v_q ? skid_q : ex_pix;

endmodule

`default_nettype wire

[rtl/ilg_chk.sv]
// Port-level checker for the remapper, attached to the top level by bind.
`default_nettype none

module ilg_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_i,
  input wire logic                            out_valid_i,
  input wire logic                            out_ready_i,
  input wire logic [ilg_pkg::PIXEL_BITS-1:0]  out_pixel_i,
  input wire logic                            pready_i
);

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready dropped");

  // Input back-pressure only happens while a result is waiting.
  a_bp_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  // Input back-pressure starts only after the sink refused a result.
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without an output stall");

  // A refused result stays offered with the same value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_i))
    else $error("stalled result changed");

endmodule

bind input_levels_gamma_map ilg_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pixel_i (out_o.pixel_out),
  .pready_i    (pready)
);

`default_nettype wire

[tb/ilg_checker.sv]
// Checker that predicts and compares remapped pixels of the levels and gamma block.
`default_nettype none

module ilg_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [ilg_pkg::PIXEL_BITS-1:0] pixel_in_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [ilg_pkg::PIXEL_BITS-1:0] pixel_out_i,
  input  wire logic               psel_i,
  input  wire logic               penable_i,
  input  wire logic               pwrite_i,
  input  wire logic [ilg_pkg::PADDR_W-1:0] paddr_i,
  input  wire logic [ilg_pkg::PDATA_W-1:0] pwdata_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  import ilg_pkg::*;

  logic [LVL_W-1:0] black_q;
  logic [LVL_W-1:0] white_q;
  logic [GAM_W-1:0] gamma_q;
  logic [PIXEL_BITS-1:0] expected_pixels[$];
  logic [63:0] root_coef[1:FRAC_BITS];

  // Floor square root, written locally.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] a);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = a;
    res = '0;
    bt  = 64'd1 << 62;
    while (bt > rem && bt != 0) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  initial begin
    root_coef[1] = floor_sqrt(64'd1 << 63);
    for (int j = 2; j <= FRAC_BITS; j++) root_coef[j] = floor_sqrt(root_coef[j-1] << 32);
  end

  // Levels, log2, division by gamma and power of two, all in integers.
  function automatic logic [PIXEL_BITS-1:0] remap_pixel(input logic [PIXEL_BITS-1:0] pix);
    longint unsigned pmax, b, w, g, den, vq, f, lg, e, r, n;
    longint num;
    int k;
    pmax = (64'd1 << PIXEL_BITS) - 1;
    b = (black_q > 1014) ? 1014 : black_q;
    w = (white_q > 1024) ? 1024 : white_q;
    g = (gamma_q < 26) ? 26 : ((gamma_q > 2560) ? 2560 : gamma_q);
    if (b + 10 > w) b = (w >= 10) ? w - 10 : 0;
    if (w < b + 10) w = b + 10;
    num = longint'(1024 * pix) - longint'(b * pmax);
    den = pmax * (w - b);
    if (num <= 0) return '0;
    if (longint'(num) >= longint'(den)) return PIX_MAX;
    vq = (longint'(num) << 32) / den;
    k = 0;
    while (vq[31] == 1'b0) begin
      vq = vq << 1;
      k++;
    end
    f = 0;
    for (int j = 0; j < FRAC_BITS; j++) begin
      vq = (vq * vq) >> 31;
      if (vq >= (64'd1 << 32)) begin
        f = f | (64'd1 << (FRAC_BITS - 1 - j));
        vq = vq >> 1;
      end
    end
    lg = (longint'(k + 1) << FRAC_BITS) - f;
    e = (lg << 8) / g;
    r = 64'd1 << 32;
    for (int j = 1; j <= FRAC_BITS; j++)
      if ((e >> (FRAC_BITS - j)) & 1) r = (r * root_coef[j]) >> 32;
    n = e >> FRAC_BITS;
    r = (n >= 33) ? 0 : (r >> n);
    r = (r * pmax + (64'd1 << 31)) >> 32;
    return (r > pmax) ? PIX_MAX : r[PIXEL_BITS-1:0];
  endfunction

  assign pending_o = expected_pixels.size();

  // Track register writes and compare every accepted result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [PIXEL_BITS-1:0] want;
    if (!rst_ni) begin
      black_q <= BLACK_RESET;
      white_q <= WHITE_RESET;
      gamma_q <= GAMMA_RESET;
      fail_count_o <= 0;
      expected_pixels.delete();
    end else begin
      if (in_valid_i && in_ready_i) expected_pixels.push_back(remap_pixel(pixel_in_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel %0d", $time, pixel_out_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want !== pixel_out_i) begin
            $display("%0t: pixel_out expected %0d actual %0d", $time, want, pixel_out_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i) begin
        case (paddr_i >> 2)
          REG_BLACK: black_q <= pwdata_i[LVL_W-1:0];
          REG_WHITE: white_q <= pwdata_i[LVL_W-1:0];
          REG_GAMMA: gamma_q <= pwdata_i[GAM_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[tb/tb_input_levels_gamma_map.sv]
// Testbench top: drives pixels and register writes, and gives the verdict.
`default_nettype none

module tb_input_levels_gamma_map;
  import ilg_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  int fail_count, pending;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit random_stall = 1'b0;

  ilg_in_if  in_ch ();
  ilg_out_if out_ch ();

  input_levels_gamma_map DUT (
    .clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ilg_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready), .pixel_in_i(in_ch.pixel_in),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .pixel_out_i(out_ch.pixel_out),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pixel_in = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stalls per item, or a long hold-off when asked.
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
      end
      gap = random_stall ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(idx) << 2; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input bit with_gaps);
    int gap;
    gap = with_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_in <= pix;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Called right after send_pixel, so this is already a falling edge.
  task automatic drain_pixels();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_levels(input int blk, input int wht, input int gam);
    write_reg(REG_BLACK, blk);
    write_reg(REG_WHITE, wht);
    write_reg(REG_GAMMA, gam);
  endtask

  initial begin
    int blk, wht, gam;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity at reset, then extremes and the out-of-range clamps.
    send_pixel(8'd0, 0); send_pixel(8'd1, 0); send_pixel(8'd128, 0);
    send_pixel(8'd254, 0); send_pixel(8'd255, 0); send_pixel(8'h55, 0); send_pixel(8'hAA, 0);
    drain_pixels();
    set_levels(1024, 0, 26);          // black above white, gamma at the minimum
    send_pixel(8'd0, 0); send_pixel(8'd3, 0); send_pixel(8'd255, 0); send_pixel(8'd254, 0);
    drain_pixels();
    set_levels(2047, 2047, 4095);     // both above range, gamma above range
    send_pixel(8'd251, 0); send_pixel(8'd253, 0); send_pixel(8'd255, 0);
    drain_pixels();
    set_levels(0, 5, 0);              // white below the gap, gamma below range
    send_pixel(8'd0, 0); send_pixel(8'd1, 0); send_pixel(8'd2, 0);
    drain_pixels();
    set_levels(100, 900, 2560);
    send_pixel(8'd25, 0); send_pixel(8'd26, 0); send_pixel(8'd200, 0); send_pixel(8'd225, 0);
    drain_pixels();

    // Random phases with random settings; the first phase also holds the output off.
    random_stall = 1'b1;
    for (int phase = 0; phase < 12; phase++) begin
      blk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 600);
      wht = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(400, 1024);
      gam = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(26, 2560);
      set_levels(blk, wht, gam);
      if (phase == 0) long_hold = 1'b1;
      for (int n = 0; n < 120; n++)
        send_pixel(PIXEL_BITS'($urandom_range(0, 255)),
                   (phase != 0) && ($urandom_range(0, 2) != 0));
      drain_pixels();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/ilg_pkg.sv
rtl/ilg_if.sv
rtl/ilg_cfg.sv
rtl/ilg_front.sv
rtl/ilg_log.sv
rtl/ilg_exp.sv
rtl/input_levels_gamma_map.sv
rtl/ilg_chk.sv
tb/ilg_checker.sv
tb/tb_input_levels_gamma_map.sv
